// File: hw/rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Shared widths, command codes, the queued item and the engine states.
// ----------------------------------------------------------------------------
package bsr_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int POS_W        = 32;
	localparam int CMD_W        = 2;
	localparam int BYTE_W       = 8;
	localparam int COUNT_W      = 11;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EOF  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_EOF,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] data;
		logic              set_end;
		logic [POS_W-1:0]  end_pos;
	} item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_ADV_RD,
		ST_ADV_CHK,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/bsr_front.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler front end
// Accepts input transfers, decodes the command and queues the item.
// ----------------------------------------------------------------------------
module bsr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [bsr_pkg::CMD_W-1:0]    cmd,
	input  logic [bsr_pkg::POS_W-1:0]    stream_index,
	input  logic [bsr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         end_flag,
	output logic                         q_valid,
	input  logic                         q_pop,
	output bsr_pkg::item_t               q_head
);
	import bsr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            dec;
	logic             push;
	logic             pop;

	function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		dec.pos     = stream_index;
		dec.data    = data_byte;
		dec.end_pos = stream_index;
		dec.set_end = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				dec.op      = OP_PUSH;
				dec.end_pos = stream_index + 1'b1;
				dec.set_end = end_flag;
			end
			CMD_EOF: begin
				dec.op      = OP_EOF;
				dec.set_end = end_flag;
			end
			CMD_READ: begin
				dec.op = OP_READ;
			end
			default: begin
				dec.op = OP_NOP;
			end
		endcase
	end

	assign item_stall = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_step(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_step(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("Queue count beyond its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("Empty queue with pointers apart.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count missed a transfer.");

endmodule

// File: hw/rtl/bsr_back.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler engine
// Executes queued items against the slot ring and valid marks, advances the
// assembled point one slot at a time and registers one result per item.
// ----------------------------------------------------------------------------
module bsr_back #(
	parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  bsr_pkg::item_t               q_head,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [bsr_pkg::BYTE_W-1:0]   read_byte,
	output logic                         read_valid,
	output logic [bsr_pkg::COUNT_W-1:0]  pending_count,
	output logic [bsr_pkg::COUNT_W-1:0]  ready_count,
	output logic                         stream_done
);
	import bsr_pkg::*;

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic [BYTE_W-1:0] store_mem [CAPACITY];
	logic              mark_mem  [CAPACITY];

	state_t              state_q;
	state_t              state_d;
	item_t               cur_q;
	logic [POS_W-1:0]    rd_q;
	logic [POS_W-1:0]    asm_q;
	logic [SLOT_W-1:0]   rd_slot_q;
	logic [SLOT_W-1:0]   asm_slot_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [CNT_W-1:0]    pend_q;
	logic                end_seen_q;
	logic [POS_W-1:0]    end_pos_q;
	logic                ended_q;
	logic                win_q;
	logic                at_asm_q;
	logic                mark_rd_q;
	logic [BYTE_W-1:0]   store_rd_q;

	logic [BYTE_W-1:0]   res_byte_q;
	logic                res_rvalid_q;
	logic [COUNT_W-1:0]  res_pend_q;
	logic [COUNT_W-1:0]  res_ready_q;
	logic                res_done_q;
	logic                res_valid_q;

	logic [POS_W-1:0]    off_d;
	logic [POS_W-1:0]    rdy_d;
	logic [POS_W-1:0]    span_d;
	logic                win_d;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   slot_d;
	logic                stream_op;
	logic                rd_go;
	logic                end_seen_n;
	logic [POS_W-1:0]    end_pos_n;
	logic                ended_n;
	logic                out_free;

	logic                pop_c;
	logic                load_c;
	logic                mark_we_c;
	logic                mark_wd_c;
	logic [SLOT_W-1:0]   mark_wa_c;
	logic [SLOT_W-1:0]   mark_ra_c;
	logic                store_we_c;
	logic                asm_inc_c;
	logic                pend_inc_c;
	logic                pend_dec_c;

	function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// Window test and slot of the head item against the current read point.
	always_comb begin
		off_d    = q_head.pos - rd_q;
		rdy_d    = asm_q - rd_q;
		win_d    = (off_d < POS_W'(CAPACITY)) && (off_d >= rdy_d);
		slot_sum = {1'b0, rd_slot_q} + {1'b0, off_d[SLOT_W-1:0]};
		if (slot_sum >= (SLOT_W + 1)'(CAPACITY)) begin
			slot_sum = slot_sum - (SLOT_W + 1)'(CAPACITY);
		end
		slot_d = slot_sum[SLOT_W-1:0];
	end

	assign span_d    = asm_q - rd_q;
	assign stream_op = (cur_q.op == OP_PUSH) || (cur_q.op == OP_EOF);
	assign rd_go     = (cur_q.op == OP_READ) && (asm_q != rd_q);
	assign out_free  = !res_valid_q || !result_stall;

	always_comb begin
		end_seen_n = end_seen_q;
		end_pos_n  = end_pos_q;
		if (stream_op && !ended_q && cur_q.set_end) begin
			end_seen_n = 1'b1;
			end_pos_n  = cur_q.end_pos;
		end
		ended_n = ended_q || (stream_op && end_seen_n && (asm_q == end_pos_n));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SLOT_W'(CAPACITY - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					if ((q_head.op == OP_PUSH) && !ended_q && win_d) begin
						state_d = ST_PROBE;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_PROBE: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!mark_rd_q && at_asm_q) begin
					state_d = ST_ADV_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_ADV_RD: begin
				state_d = ST_ADV_CHK;
			end
			ST_ADV_CHK: begin
				if (mark_rd_q && (span_d < POS_W'(CAPACITY))) begin
					state_d = ST_ADV_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		pop_c      = 1'b0;
		load_c     = 1'b0;
		mark_we_c  = 1'b0;
		mark_wd_c  = 1'b0;
		mark_wa_c  = asm_slot_q;
		mark_ra_c  = asm_slot_q;
		store_we_c = 1'b0;
		asm_inc_c  = 1'b0;
		pend_inc_c = 1'b0;
		pend_dec_c = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mark_we_c = 1'b1;
				mark_wa_c = clr_q;
			end
			ST_IDLE: begin
				pop_c = q_valid;
			end
			ST_PROBE: begin
				mark_ra_c = slot_q;
			end
			ST_CHECK: begin
				if (!mark_rd_q) begin
					store_we_c = 1'b1;
					if (at_asm_q) begin
						asm_inc_c = 1'b1;
					end else begin
						mark_we_c  = 1'b1;
						mark_wd_c  = 1'b1;
						mark_wa_c  = slot_q;
						pend_inc_c = 1'b1;
					end
				end
			end
			ST_ADV_RD: begin
				mark_ra_c = asm_slot_q;
			end
			ST_ADV_CHK: begin
				if (mark_rd_q && (span_d < POS_W'(CAPACITY))) begin
					mark_we_c  = 1'b1;
					asm_inc_c  = 1'b1;
					pend_dec_c = 1'b1;
				end
			end
			ST_FINISH: begin
				load_c = out_free;
			end
			default: begin
				pop_c = 1'b0;
			end
		endcase
	end

	assign q_pop = pop_c;

	always_ff @(posedge clk) begin
		if (mark_we_c) begin
			mark_mem[mark_wa_c] <= mark_wd_c;
		end
		mark_rd_q <= mark_mem[mark_ra_c];
	end

	always_ff @(posedge clk) begin
		if (store_we_c) begin
			store_mem[slot_q] <= cur_q.data;
		end
		store_rd_q <= store_mem[rd_slot_q];
	end

	always_ff @(posedge clk) begin
		if (pop_c) begin
			cur_q    <= q_head;
			win_q    <= win_d;
			at_asm_q <= (q_head.pos == asm_q);
			slot_q   <= slot_d;
		end
		if (load_c) begin
			res_byte_q   <= rd_go ? store_rd_q : '0;
			res_rvalid_q <= rd_go;
			res_pend_q   <= COUNT_W'(pend_q);
			res_ready_q  <= COUNT_W'(span_d - {{(POS_W - 1){1'b0}}, rd_go});
			res_done_q   <= ended_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_q        <= '0;
			asm_q       <= '0;
			rd_slot_q   <= '0;
			asm_slot_q  <= '0;
			pend_q      <= '0;
			end_seen_q  <= 1'b0;
			end_pos_q   <= '0;
			ended_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= slot_step(clr_q);
			end
			if (asm_inc_c) begin
				asm_q      <= asm_q + 1'b1;
				asm_slot_q <= slot_step(asm_slot_q);
			end
			if (pend_inc_c) begin
				pend_q <= pend_q + 1'b1;
			end else if (pend_dec_c) begin
				pend_q <= pend_q - 1'b1;
			end
			if (load_c) begin
				end_seen_q <= end_seen_n;
				end_pos_q  <= end_pos_n;
				ended_q    <= ended_n;
				if (rd_go) begin
					rd_q      <= rd_q + 1'b1;
					rd_slot_q <= slot_step(rd_slot_q);
				end
			end
			if (load_c) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign read_byte     = res_byte_q;
	assign read_valid    = res_rvalid_q;
	assign pending_count = res_pend_q;
	assign ready_count   = res_ready_q;
	assign stream_done   = res_done_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(CAPACITY))
		else $error("Pending bytes exceed the ring capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		span_d <= POS_W'(CAPACITY))
		else $error("Assembled bytes exceed the ring capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q)
		else $error("Stream end cleared after it was reached.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> end_seen_q)
		else $error("Stream ended without a recorded end position.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> win_q)
		else $error("Slot probed for a byte outside the window.");

endmodule

// File: hw/rtl/byte_stream_reassembler.sv
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Reassembles an out-of-order byte stream in a ring of CAPACITY slots and
// returns one status result for every command.
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   cmd, stream_index, data_byte, end_flag
//   result    result_valid/result_stall read_byte, read_valid, pending_count,
//                                       ready_count, stream_done
//
// A read, an end marker or a dropped byte goes from idle straight to the
// finish state in the engine; a stored byte also passes the probe and check
// states, plus one valid-mark memory read for every slot that it lets the
// assembled point advance over. After reset the engine clears the valid
// marks slot by slot; up to two items are queued meanwhile.
// The two-entry queue lets input transfers continue while the engine works
// or a result is stalled.
// ----------------------------------------------------------------------------
module byte_stream_reassembler #(
	parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [bsr_pkg::CMD_W-1:0]    cmd,
	input  logic [bsr_pkg::POS_W-1:0]    stream_index,
	input  logic [bsr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         end_flag,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [bsr_pkg::BYTE_W-1:0]   read_byte,
	output logic                         read_valid,
	output logic [bsr_pkg::COUNT_W-1:0]  pending_count,
	output logic [bsr_pkg::COUNT_W-1:0]  ready_count,
	output logic                         stream_done
);
	import bsr_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_head;

	bsr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.stream_index (stream_index),
		.data_byte    (data_byte),
		.end_flag     (end_flag),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head)
	);

	bsr_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_head        (q_head),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.read_byte     (read_byte),
		.read_valid    (read_valid),
		.pending_count (pending_count),
		.ready_count   (ready_count),
		.stream_done   (stream_done)
	);

endmodule
